FILE: src/gdsf_pkg.sv
// Shared types, register codes and stencil coefficients for the dissipation filter.
`default_nettype none
package gdsf_pkg;

    localparam int LINE_ROWS  = 12;
    localparam int TAPS       = 13;
    localparam int CENTER     = 6;
    localparam int HALF_TAPS  = 7;
    localparam int ACC_SHIFT  = 28;
    localparam int COEF_W     = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ROWS_W     = 16;
    localparam int COLS_REG_W = 11;
    localparam int DAMP_W     = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_ORDER_SELECT = 2'd0;
    localparam t_cfg_idx REG_DAMPING      = 2'd1;
    localparam t_cfg_idx REG_GRID_ROWS    = 2'd2;
    localparam t_cfg_idx REG_GRID_COLS    = 2'd3;

    typedef logic [3:0] t_slot;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    function automatic t_slot slot_back(input t_slot s, input logic [3:0] m);
        logic [4:0] d;
        d = {1'b0, s} + 5'd12 - {1'b0, m};
        if (d >= 5'd12) begin
            d = d - 5'd12;
        end
        return d[3:0];
    endfunction

    // sixth order taps are scaled by 64 so both orders share one final shift
    function automatic logic signed [COEF_W-1:0] coef(input logic mode, input logic [3:0] j);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (mode) begin
            unique case (j)
                4'd0: c = 12'sd1;
                4'd1: c = -12'sd12;
                4'd2: c = 12'sd66;
                4'd3: c = -12'sd220;
                4'd4: c = 12'sd495;
                4'd5: c = -12'sd792;
                4'd6: c = 12'sd924;
                default: c = '0;
            endcase
        end else begin
            unique case (j)
                4'd3: c = -12'sd64;
                4'd4: c = 12'sd384;
                4'd5: c = -12'sd960;
                4'd6: c = 12'sd1280;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/gdsf_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module gdsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

FILE: src/gdsf_front.sv
// Raster position tracking, line buffers and row/column tap windows.
`default_nettype none
module gdsf_front import gdsf_pkg::*; #(
    parameter int MAX_COLS     = 1024,
    parameter int SAMPLE_WIDTH = 32,
    localparam int CW = $clog2(MAX_COLS)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_adv,
    input  wire logic                           i_accept,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_frame_start,
    input  wire logic                           i_order,
    input  wire logic        [ROWS_W-1:0]       i_rows,
    input  wire logic        [COLS_REG_W-1:0]   i_cols,
    output t_ctl                                o_ctl,
    output logic             [ROWS_W-1:0]       o_row,
    output logic             [CW-1:0]           o_col,
    output logic signed      [SAMPLE_WIDTH-1:0] o_va [TAPS],
    output logic signed      [SAMPLE_WIDTH-1:0] o_ha [TAPS]
);

    logic [ROWS_W-1:0] r_row, n_row, cur_row, rows_eff;
    logic [CW-1:0]     r_col, n_col, cur_col, pb_addr;
    t_slot             r_slot, n_slot, cur_slot, pb_slot;
    logic [3:0]        rad;
    logic [CW:0]       cols_eff;
    logic [CW+1:0]     col_ext, cb;
    logic              emit, last;

    logic signed [SAMPLE_WIDTH-1:0] rd_a [LINE_ROWS];
    logic signed [SAMPLE_WIDTH-1:0] rd_b [LINE_ROWS];

    logic                           r1_valid, r1_emit, r1_last;
    logic        [ROWS_W-1:0]       r1_row;
    logic        [CW-1:0]           r1_col;
    logic signed [SAMPLE_WIDTH-1:0] r1_u;
    t_slot                          r1_slot, r1_pb_slot;

    logic signed [SAMPLE_WIDTH-1:0] va [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] r_hwin [TAPS];

    logic                           r2_valid, r2_last;
    logic        [ROWS_W-1:0]       r2_row;
    logic        [CW-1:0]           r2_col;
    logic signed [SAMPLE_WIDTH-1:0] r2_va [TAPS];

    always_comb begin
        rad      = i_order ? 4'd6 : 4'd3;
        rows_eff = (i_rows == '0) ? ROWS_W'(1) : i_rows;
        if (i_cols == '0) begin
            cols_eff = (CW+1)'(1);
        end else if (32'(i_cols) > MAX_COLS) begin
            cols_eff = (CW+1)'(MAX_COLS);
        end else begin
            cols_eff = (CW+1)'(i_cols);
        end
        cur_row  = i_frame_start ? '0 : r_row;
        cur_col  = i_frame_start ? '0 : r_col;
        cur_slot = i_frame_start ? '0 : r_slot;
        col_ext  = (CW+2)'(cur_col);

        emit = ({1'b0, cur_row} >= {12'b0, rad, 1'b0}) && (cur_row < rows_eff)
            && (col_ext >= (CW+2)'(rad))
            && (col_ext + (CW+2)'(rad) < (CW+2)'(cols_eff));
        last = ({1'b0, cur_row} + 17'd1 == {1'b0, rows_eff})
            && (col_ext + (CW+2)'(rad) + (CW+2)'(1) == (CW+2)'(cols_eff));

        n_row  = cur_row;
        n_slot = cur_slot;
        if (col_ext + (CW+2)'(1) >= (CW+2)'(cols_eff)) begin
            n_col = '0;
            if ({1'b0, cur_row} + 17'd1 >= {1'b0, rows_eff}) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = cur_row + ROWS_W'(1);
                n_slot = (cur_slot == t_slot'(LINE_ROWS - 1)) ? '0 : cur_slot + 4'd1;
            end
        end else begin
            n_col = cur_col + CW'(1);
        end

        // fetch the centre row R columns ahead, wrapping into the next centre row
        cb = col_ext + (CW+2)'(rad);
        if (cb >= (CW+2)'(cols_eff)) begin
            pb_addr = CW'(cb - (CW+2)'(cols_eff));
            pb_slot = slot_back(cur_slot, rad - 4'd1);
        end else begin
            pb_addr = cb[CW-1:0];
            pb_slot = slot_back(cur_slot, rad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
        gdsf_ram #(
            .WIDTH(SAMPLE_WIDTH),
            .DEPTH(MAX_COLS)
        ) u_line (
            .i_clk     (i_clk),
            .i_we      (i_accept && (cur_slot == t_slot'(k))),
            .i_waddr   (cur_col),
            .i_wdata   (i_sample),
            .i_re      (i_adv),
            .i_raddr_a (cur_col),
            .i_raddr_b (pb_addr),
            .o_rdata_a (rd_a[k]),
            .o_rdata_b (rd_b[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_emit    <= emit;
            r1_last    <= last;
            r1_row     <= cur_row - ROWS_W'(rad);
            r1_col     <= cur_col;
            r1_u       <= i_sample;
            r1_slot    <= cur_slot;
            r1_pb_slot <= pb_slot;
        end
    end

    // tap j holds row (r - 6 - R + j); the arriving sample is tap 6 + R, the last one used
    always_comb begin
        int m;
        for (int j = 0; j < TAPS; j++) begin
            m = CENTER + int'(rad) - j;
            if (m == 0) begin
                va[j] = r1_u;
            end else if (m >= 1 && m <= 2 * int'(rad)) begin
                va[j] = rd_a[slot_back(r1_slot, 4'(m))];
            end else begin
                va[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r1_valid) begin
            for (int j = 0; j < TAPS - 1; j++) begin
                r_hwin[j] <= r_hwin[j+1];
            end
            r_hwin[TAPS-1] <= rd_b[r1_pb_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid && r1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_last <= r1_last;
            r2_row  <= r1_row;
            r2_col  <= r1_col;
            r2_va   <= va;
        end
    end

    always_comb begin
        int idx;
        for (int j = 0; j < TAPS; j++) begin
            idx = j + CENTER - int'(rad);
            if (idx < TAPS && j >= CENTER - int'(rad)) begin
                o_ha[j] = r_hwin[4'(idx)];
            end else begin
                o_ha[j] = '0;
            end
        end
    end

    assign o_ctl.valid = r2_valid;
    assign o_ctl.last  = r2_last;
    assign o_row       = r2_row;
    assign o_col       = r2_col;
    assign o_va        = r2_va;

endmodule
`default_nettype wire

FILE: src/gdsf_filter.sv
// Stencil arithmetic: tap sums, damping product, rounding and saturation.
`default_nettype none
module gdsf_filter import gdsf_pkg::*; #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COL_W        = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_adv,
    input  wire logic                           i_order,
    input  wire logic        [DAMP_W-1:0]       i_damping,
    input  wire t_ctl                           i_ctl,
    input  wire logic        [ROWS_W-1:0]       i_row,
    input  wire logic        [COL_W-1:0]        i_col,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_va [TAPS],
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_ha [TAPS],
    output t_ctl                                o_ctl,
    output logic             [ROWS_W-1:0]       o_row,
    output logic             [COL_W-1:0]        o_col,
    output logic signed      [SAMPLE_WIDTH-1:0] o_filtered
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int PW   = W + 2;
    localparam int PRW  = PW + COEF_W;
    localparam int SUMW = PRW + 3;
    localparam int MW   = SUMW + DAMP_W + 1;
    localparam int QW   = MW - ACC_SHIFT + 1;
    localparam int NSTG = 6;

    t_ctl              r_ctl [NSTG];
    logic [ROWS_W-1:0] r_row [NSTG];
    logic [COL_W-1:0]  r_col [NSTG];
    logic signed [W-1:0] r_ctr [NSTG-1];

    logic signed [PW-1:0]   ps [HALF_TAPS];
    logic signed [PW-1:0]   r_ps [HALF_TAPS];
    logic signed [PRW-1:0]  r_pr [HALF_TAPS];
    logic signed [SUMW-1:0] r_part [4];
    logic signed [SUMW-1:0] r_sum;
    logic signed [MW-1:0]   r_prod;
    logic signed [DAMP_W:0] dneg;
    logic signed [MW-1:0]   rnd;
    logic signed [QW-1:0]   q;
    logic signed [W-1:0]    sat;
    logic signed [W-1:0]    r_out;

    always_comb begin
        for (int j = 0; j < CENTER; j++) begin
            ps[j] = PW'(i_va[j]) + PW'(i_va[TAPS-1-j]) + PW'(i_ha[j]) + PW'(i_ha[TAPS-1-j]);
        end
        ps[CENTER] = PW'(i_va[CENTER]) + PW'(i_ha[CENTER]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_ctl[s].valid <= 1'b0;
            end
        end else if (i_adv) begin
            r_ctl[0].valid <= i_ctl.valid;
            for (int s = 1; s < NSTG; s++) begin
                r_ctl[s].valid <= r_ctl[s-1].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl[0].last <= i_ctl.last;
            r_row[0]      <= i_row;
            r_col[0]      <= i_col;
            r_ctr[0]      <= i_va[CENTER];
            for (int s = 1; s < NSTG; s++) begin
                r_ctl[s].last <= r_ctl[s-1].last;
                r_row[s]      <= r_row[s-1];
                r_col[s]      <= r_col[s-1];
            end
            for (int s = 1; s < NSTG - 1; s++) begin
                r_ctr[s] <= r_ctr[s-1];
            end
        end
    end

    assign dneg = -$signed({1'b0, i_damping});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ps <= ps;
            for (int j = 0; j < HALF_TAPS; j++) begin
                r_pr[j] <= PRW'(r_ps[j]) * PRW'(coef(i_order, 4'(j)));
            end
            r_part[0] <= SUMW'(r_pr[0]) + SUMW'(r_pr[1]);
            r_part[1] <= SUMW'(r_pr[2]) + SUMW'(r_pr[3]);
            r_part[2] <= SUMW'(r_pr[4]) + SUMW'(r_pr[5]);
            r_part[3] <= SUMW'(r_pr[6]);
            r_sum     <= r_part[0] + r_part[1] + r_part[2] + r_part[3];
            r_prod    <= MW'(r_sum) * MW'(dneg);
            r_out     <= sat;
        end
    end

    // round half up, add the centre sample, then clamp to the sample range
    always_comb begin
        rnd = (r_prod + (MW'(1) <<< (ACC_SHIFT - 1))) >>> ACC_SHIFT;
        q   = QW'(r_ctr[NSTG-2]) + QW'(rnd);
        if (q[QW-1:W-1] == '0 || q[QW-1:W-1] == '1) begin
            sat = q[W-1:0];
        end else if (q[QW-1]) begin
            sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    assign o_ctl      = r_ctl[NSTG-1];
    assign o_row      = r_row[NSTG-1];
    assign o_col      = r_col[NSTG-1];
    assign o_filtered = r_out;

endmodule
`default_nettype wire

FILE: src/grid_dissipation_stencil_filter_unit.sv
// Streaming 2-D dissipation filter: takes one raster sample per cycle and returns
// u - damping * (row stencil + column stencil) for every interior point, using a
// 7-tap or 13-tap binomial stencil. One sample is taken per cycle when the output is
// not stalled; each transaction passes through two stages for the line RAM read and
// tap windows, then six for the arithmetic. Twelve line RAMs with one write and two
// read ports each keep the rate at one sample per cycle. Points within the stencil
// radius of a border produce no transaction. Line RAMs need no clearing pass.
`default_nettype none
module grid_dissipation_stencil_filter_unit import gdsf_pkg::*; #(
    parameter int MAX_COLS     = 1024,
    parameter int SAMPLE_WIDTH = 32,
    localparam int COL_W = $clog2(MAX_COLS)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_frame_start,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed      [SAMPLE_WIDTH-1:0] o_filtered,
    output logic             [ROWS_W-1:0]       o_out_row,
    output logic             [COL_W-1:0]        o_out_col,
    output logic                                o_last_of_frame
);

    logic                  r_order;
    logic [DAMP_W-1:0]     r_damping;
    logic [ROWS_W-1:0]     r_rows;
    logic [COLS_REG_W-1:0] r_cols;

    logic adv, accept;

    t_ctl                           fr_ctl, f_ctl;
    logic        [ROWS_W-1:0]       fr_row;
    logic        [COL_W-1:0]        fr_col;
    logic signed [SAMPLE_WIDTH-1:0] fr_va [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] fr_ha [TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= 1'b0;
            r_damping <= '0;
            r_rows    <= ROWS_W'(64);
            r_cols    <= COLS_REG_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ORDER_SELECT: r_order   <= i_cfg_data[0];
                REG_DAMPING:      r_damping <= i_cfg_data[DAMP_W-1:0];
                REG_GRID_ROWS:    r_rows    <= i_cfg_data[ROWS_W-1:0];
                REG_GRID_COLS:    r_cols    <= i_cfg_data[COLS_REG_W-1:0];
            endcase
        end
    end

    // advance the whole pipeline unless the output transaction is held
    assign adv        = !f_ctl.valid || !i_out_stall;
    assign accept     = i_in_valid && adv;
    assign o_in_stall = !adv;

    gdsf_front #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_accept      (accept),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .i_order       (r_order),
        .i_rows        (r_rows),
        .i_cols        (r_cols),
        .o_ctl         (fr_ctl),
        .o_row         (fr_row),
        .o_col         (fr_col),
        .o_va          (fr_va),
        .o_ha          (fr_ha)
    );

    gdsf_filter #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COL_W        (COL_W)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_order    (r_order),
        .i_damping  (r_damping),
        .i_ctl      (fr_ctl),
        .i_row      (fr_row),
        .i_col      (fr_col),
        .i_va       (fr_va),
        .i_ha       (fr_ha),
        .o_ctl      (f_ctl),
        .o_row      (o_out_row),
        .o_col      (o_out_col),
        .o_filtered (o_filtered)
    );

    assign o_out_valid     = f_ctl.valid;
    assign o_last_of_frame = f_ctl.last;

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while output transaction is held");

    a_row_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_row >= ROWS_W'(3)))
        else $error("result row inside the border");

    a_col_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_col >= COL_W'(3)))
        else $error("result column inside the border");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for grid_dissipation_stencil_filter_unit: frames of samples against a stencil predictor.
module tb_top;
    import gdsf_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic [15:0]        row;
        logic [9:0]         col;
        logic               last;
    } t_filt_res;

    typedef struct {
        logic        order;
        logic [15:0] damp;
        logic [15:0] rows;
        logic [10:0] cols;
        int          pattern;
        logic [31:0] level;
        logic        known;
    } t_frame_row;

    localparam int PAT_CONST = 0;
    localparam int PAT_RAND  = 1;
    localparam int PAT_CHECK = 2;
    localparam int PAT_SMALL = 3;
    localparam int PAT_EDGE  = 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_sample = '0;
    logic               i_frame_start = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_filtered;
    logic [15:0]        o_out_row;
    logic [9:0]         o_out_col;
    logic               o_last_of_frame;

    grid_dissipation_stencil_filter_unit uut (.*);

    always #5 i_clk = ~i_clk;

    t_filt_res   pending_q[$];
    longint      line_mem[LINE_ROWS*1024];
    int unsigned pos_row, pos_col;
    logic        cur_order;
    logic [15:0] cur_damp, cur_rows;
    logic [10:0] cur_cols;
    int          errors = 0;
    int          items_sent = 0;
    bit          calm = 0;
    bit          force_known = 0;
    logic [31:0] known_level;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic longint tap_weight(input logic order, input int k);
        longint w6[7]   = '{-1, 6, -15, 20, -15, 6, -1};
        longint w12[13] = '{1, -12, 66, -220, 495, -792, 924, -792, 495, -220, 66, -12, 1};
        return order ? w12[k] : w6[k];
    endfunction

    function automatic longint mem_at(input int unsigned r, input int unsigned c);
        return line_mem[(r % LINE_ROWS) * 1024 + c];
    endfunction

    task automatic filter_sample(input logic signed [31:0] s, input logic fs);
        int unsigned rows, cols, rad, shf, r, c;
        longint u, sv, shs, t, th, tl, q, ctr, vk;
        t_filt_res res;
        rows = (cur_rows == 0) ? 1 : cur_rows;
        cols = (cur_cols == 0) ? 1 : ((cur_cols > 1024) ? 1024 : cur_cols);
        rad = cur_order ? 6 : 3;
        shf = cur_order ? 28 : 22;
        u = s;
        if (fs) begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        if (r >= 2*rad && r < rows && c >= rad && c + rad < cols) begin
            sv = 0;
            shs = 0;
            for (int k = 0; k <= 2*rad; k++) begin
                vk = (k == 2*rad) ? u : mem_at(r - 2*rad + k, c);
                if (k == rad) ctr = vk;
                sv += tap_weight(cur_order, k) * vk;
                shs += tap_weight(cur_order, k) * mem_at(r - rad, c - rad + k);
            end
            t = -(sv + shs);
            th = t >>> shf;
            tl = t - (th <<< shf);
            q = ctr + longint'(cur_damp) * th
                + ((64'sd1 <<< (shf - 1)) + longint'(cur_damp) * tl) / (64'sd1 <<< shf);
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            res.value = force_known ? known_level : q[31:0];
            res.row = 16'(r - rad);
            res.col = 10'(c);
            res.last = (r + 1 == rows) && (c + rad + 1 == cols);
            pending_q.push_back(res);
        end
        if (c < 1024) line_mem[(r % LINE_ROWS) * 1024 + c] = u;
        if (c + 1 >= cols) begin
            pos_col = 0;
            pos_row = (r + 1 >= rows) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_filt_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected transaction row %0d col %0d", o_out_row, o_out_col));
            end else begin
                e = pending_q.pop_front();
                if (o_filtered !== e.value)
                    report($sformatf("filtered %h, want %h at (%0d,%0d)",
                                     o_filtered, e.value, e.row, e.col));
                if (o_out_row !== e.row)
                    report($sformatf("row %0d, want %0d", o_out_row, e.row));
                if (o_out_col !== e.col)
                    report($sformatf("col %0d, want %0d", o_out_col, e.col));
                if (o_last_of_frame !== e.last)
                    report($sformatf("last %b, want %b at (%0d,%0d)",
                                     o_last_of_frame, e.last, e.row, e.col));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!calm && $urandom_range(0, 11) == 0) begin
            i_out_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            i_out_stall = 1'b0;
        end
    end

    task automatic send(input logic [31:0] s, input logic fs);
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sample = s;
        i_frame_start = fs;
        do @(posedge i_clk); while (o_in_stall);
        filter_sample(s, fs);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid = 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_ORDER_SELECT: cur_order = val[0];
            REG_DAMPING:      cur_damp = val;
            REG_GRID_ROWS:    cur_rows = val;
            default:          cur_cols = val[10:0];
        endcase
    endtask

    function automatic logic [31:0] pick_sample(input int pattern, input logic [31:0] level,
                                               input int unsigned r, input int unsigned c);
        case (pattern)
            PAT_CONST: return level;
            PAT_CHECK: return ((r + c) & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            PAT_SMALL: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 8;
            PAT_EDGE:  return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                              ^ 32'($urandom_range(0, 3));
            default:   return $urandom();
        endcase
    endfunction

    // send n_rows rows with frame start on the first sample; fewer rows than configured abandon the frame early
    task automatic send_frame(input int pattern, input logic [31:0] level,
                              input int unsigned n_rows, input int unsigned n_cols);
        for (int unsigned r = 0; r < n_rows; r++)
            for (int unsigned c = 0; c < n_cols; c++)
                send(pick_sample(pattern, level, r, c), (r == 0 && c == 0));
    endtask

    task automatic set_config(input logic order, input logic [15:0] damp,
                              input logic [15:0] rows, input logic [10:0] cols);
        drain();
        write_reg(REG_ORDER_SELECT, {15'd0, order});
        write_reg(REG_DAMPING, damp);
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_GRID_COLS, {5'd0, cols});
    endtask

    t_frame_row directed[6] = '{
        '{1'b0, 16'h0000, 16'd7,  11'd7,  PAT_CONST, 32'h1234_5678, 1'b1},
        '{1'b0, 16'hFFFF, 16'd7,  11'd7,  PAT_CONST, 32'h7FFF_FFFF, 1'b1},
        '{1'b1, 16'hFFFF, 16'd13, 11'd13, PAT_CONST, 32'h8000_0000, 1'b1},
        '{1'b0, 16'hFFFF, 16'd8,  11'd9,  PAT_CHECK, 32'h0,         1'b0},
        '{1'b1, 16'h8000, 16'd14, 11'd15, PAT_RAND,  32'h0,         1'b0},
        '{1'b0, 16'h0001, 16'd7,  11'd7,  PAT_RAND,  32'h0,         1'b0}
    };

    initial begin
        int unsigned nr, nc, pat;
        cur_order = 1'b0;
        cur_damp = '0;
        cur_rows = 16'd64;
        cur_cols = 11'd1024;
        pos_row = 0;
        pos_col = 0;
        foreach (line_mem[i]) line_mem[i] = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            set_config(directed[i].order, directed[i].damp, directed[i].rows, directed[i].cols);
            force_known = directed[i].known;
            known_level = directed[i].level;
            send_frame(directed[i].pattern, directed[i].level,
                       directed[i].rows, directed[i].cols);
        end
        force_known = 0;

        // tallest grid: start a frame, then abandon it
        set_config(1'b0, 16'hFFFF, 16'hFFFF, 11'd7);
        send_frame(PAT_RAND, 0, 9, 7);
        send_frame(PAT_EDGE, 0, 8, 7);
        // wide grid, once
        set_config(1'b1, 16'h0000, 16'd13, 11'd40);
        send_frame(PAT_SMALL, 0, 13, 40);

        while (items_sent < 1750) begin
            if (items_sent > 1450) calm = 1;
            nr = $urandom_range(7, 18);
            nc = $urandom_range(7, 20);
            case ($urandom_range(0, 3))
                0: set_config(1'($urandom), 16'hFFFF, 16'(nr), 11'(nc));
                1: set_config(1'($urandom), 16'h0000, 16'(nr), 11'(nc));
                default: set_config(1'($urandom), 16'($urandom), 16'(nr), 11'(nc));
            endcase
            repeat ($urandom_range(1, 3)) begin
                pat = $urandom_range(0, 4);
                if ($urandom_range(0, 7) == 0)
                    send_frame(pat, $urandom(), $urandom_range(1, nr), nc);
                else
                    send_frame(pat, $urandom(), nr, nc);
            end
        end

        drain();
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
